// ===== design/wrpp_pkg.sv =====
`timescale 1ns / 1ps

package wrpp_pkg;

  localparam int MAX_RECTS  = 64;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = $clog2(MAX_RECTS);
  localparam int CNT_W      = $clog2(MAX_RECTS + 1);
  localparam int RAND_W     = 40;
  localparam int SPAN_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * COORD_BITS + 1;
  localparam int OFF_W      = 2 * COORD_BITS;
  localparam int PREFIX_W   = 39;
  localparam int RECT_W     = 3 * COORD_BITS;
  localparam int STEP_W     = $clog2(RAND_W + 1);
  localparam int RIDX_W     = 6;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_PICK   = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_INVERTED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_APPEND,
    S_MOD,
    S_SRCH,
    S_CMP,
    S_FETCH,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]                   mode;
    logic signed [COORD_BITS-1:0] x_left;
    logic signed [COORD_BITS-1:0] y_bottom;
    logic signed [COORD_BITS-1:0] x_right;
    logic signed [COORD_BITS-1:0] y_top;
    logic [RAND_W-1:0]            random_value;
  } in_req_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic [RIDX_W-1:0]            rect_index;
    logic [1:0]                   status;
  } out_resp_t;

endpackage

// ===== design/wrpp_ram.sv =====
`timescale 1ns / 1ps

module wrpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/weighted_rect_point_picker_core.sv =====
`timescale 1ns / 1ps

// Uniform random integer point over a table of up to 64 non-overlapping
// rectangles with inclusive edges. Clear and rejected requests go straight
// to the output state, append runs a bit-serial 17 x 17 shift-add multiply
// for the point count, and pick runs a 40-step restoring modulo of the draw
// by the total, a binary search over the prefix memory with each probe
// waiting on its registered read port, then a 32-step restoring divide by
// the height. One request is worked at a time; a finished result waits in
// the output register while the next request is taken.
module weighted_rect_point_picker_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  wrpp_pkg::in_req_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output wrpp_pkg::out_resp_t out_data
);

  localparam int CW = wrpp_pkg::COORD_BITS;
  localparam int IW = wrpp_pkg::IDX_W;

  wrpp_pkg::state_t    state_r, state_nxt;
  logic [wrpp_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [wrpp_pkg::PREFIX_W-1:0] total_r, total_nxt;
  logic [wrpp_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [wrpp_pkg::RAND_W-1:0]   num_r, num_nxt;
  logic [wrpp_pkg::RAND_W-1:0]   rem_r, rem_nxt;
  logic [wrpp_pkg::PREFIX_W-1:0] dvs_r, dvs_nxt;
  logic [wrpp_pkg::PROD_W-1:0]   acc_r, acc_nxt;
  logic [wrpp_pkg::PROD_W-1:0]   mcand_r, mcand_nxt;
  logic [wrpp_pkg::SPAN_W-1:0]   mplier_r, mplier_nxt;
  logic [CW-1:0]                 x_r, x_nxt;
  logic [CW-1:0]                 y_r, y_nxt;
  logic [CW-1:0]                 hm1_r, hm1_nxt;
  logic [IW-1:0]                 lo_r, lo_nxt;
  logic [IW-1:0]                 hi_r, hi_nxt;
  wrpp_pkg::out_resp_t           res_r, res_nxt;
  wrpp_pkg::out_resp_t           out_data_r, out_data_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic                          pfx_we, rect_we;
  logic [IW-1:0]                 pfx_raddr, waddr;
  logic [wrpp_pkg::PREFIX_W-1:0] pfx_wdata, pfx_rdata;
  logic [wrpp_pkg::RECT_W-1:0]   rect_wdata, rect_rdata;

  // shared restoring divide step
  logic [wrpp_pkg::RAND_W-1:0]   trial;
  logic [wrpp_pkg::RAND_W:0]     diff;
  logic                          qbit;

  logic [wrpp_pkg::SPAN_W-1:0]   span_w, span_h;
  logic [IW-1:0]                 mid;
  logic [wrpp_pkg::PREFIX_W-1:0] prev_total;
  logic [wrpp_pkg::OFF_W-1:0]    off_in;

  assign trial = {rem_r[wrpp_pkg::RAND_W-2:0], num_r[wrpp_pkg::RAND_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_r};
  assign qbit  = !diff[wrpp_pkg::RAND_W];

  assign span_w = {in_data.x_right[CW-1], in_data.x_right}
                - {in_data.x_left[CW-1], in_data.x_left} + 1'b1;
  assign span_h = {in_data.y_top[CW-1], in_data.y_top}
                - {in_data.y_bottom[CW-1], in_data.y_bottom} + 1'b1;
  assign mid    = lo_r + ((hi_r - lo_r) >> 1);
  assign prev_total = (count_r == '0) ? '0 : total_r;
  assign off_in = rem_r[wrpp_pkg::OFF_W-1:0]
                - ((lo_r == '0) ? '0 : pfx_rdata[wrpp_pkg::OFF_W-1:0]);

  assign waddr      = count_r[IW-1:0];
  assign pfx_wdata  = prev_total + wrpp_pkg::PREFIX_W'(acc_r);
  assign rect_wdata = {x_r, y_r, hm1_r};

  wrpp_ram #(.WIDTH(wrpp_pkg::PREFIX_W), .DEPTH(wrpp_pkg::MAX_RECTS)) u_pfx_ram (
    .clk   (clk),
    .we    (pfx_we),
    .waddr (waddr),
    .wdata (pfx_wdata),
    .raddr (pfx_raddr),
    .rdata (pfx_rdata)
  );

  wrpp_ram #(.WIDTH(wrpp_pkg::RECT_W), .DEPTH(wrpp_pkg::MAX_RECTS)) u_rect_ram (
    .clk   (clk),
    .we    (rect_we),
    .waddr (waddr),
    .wdata (rect_wdata),
    .raddr (lo_r),
    .rdata (rect_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wrpp_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_r    <= total_nxt;
    step_r     <= step_nxt;
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    acc_r      <= acc_nxt;
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    hm1_r      <= hm1_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    step_nxt      = step_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    hm1_nxt       = hm1_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    pfx_we        = 1'b0;
    rect_we       = 1'b0;
    pfx_raddr     = lo_r - 1'b1;

    unique case (state_r)
      wrpp_pkg::S_IDLE: begin
        if (in_valid) begin
          res_nxt   = '0;
          state_nxt = wrpp_pkg::S_OUT;
          unique case (in_data.mode)
            wrpp_pkg::MODE_CLEAR: begin
              count_nxt = '0;
            end
            wrpp_pkg::MODE_APPEND: begin
              if (in_data.x_right < in_data.x_left || in_data.y_top < in_data.y_bottom) begin
                res_nxt.status = wrpp_pkg::ST_INVERTED;
              end else if (count_r == wrpp_pkg::CNT_W'(wrpp_pkg::MAX_RECTS)) begin
                res_nxt.status = wrpp_pkg::ST_FULL;
              end else begin
                x_nxt      = in_data.x_left;
                y_nxt      = in_data.y_bottom;
                hm1_nxt    = span_h[CW-1:0] - 1'b1;
                acc_nxt    = '0;
                mcand_nxt  = wrpp_pkg::PROD_W'(span_w);
                mplier_nxt = span_h;
                step_nxt   = wrpp_pkg::STEP_W'(wrpp_pkg::SPAN_W);
                state_nxt  = wrpp_pkg::S_MUL;
              end
            end
            wrpp_pkg::MODE_PICK: begin
              if (count_r == '0) begin
                res_nxt.status = wrpp_pkg::ST_EMPTY;
              end else begin
                num_nxt   = in_data.random_value;
                rem_nxt   = '0;
                dvs_nxt   = total_r;
                step_nxt  = wrpp_pkg::STEP_W'(wrpp_pkg::RAND_W);
                state_nxt = wrpp_pkg::S_MOD;
              end
            end
            default: ;
          endcase
        end
      end
      wrpp_pkg::S_MUL: begin
        if (mplier_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        step_nxt   = step_r - 1'b1;
        if (step_r == wrpp_pkg::STEP_W'(1)) begin
          state_nxt = wrpp_pkg::S_APPEND;
        end
      end
      wrpp_pkg::S_APPEND: begin
        pfx_we    = 1'b1;
        rect_we   = 1'b1;
        total_nxt = pfx_wdata;
        count_nxt = count_r + 1'b1;
        state_nxt = wrpp_pkg::S_OUT;
      end
      wrpp_pkg::S_MOD: begin
        rem_nxt  = qbit ? diff[wrpp_pkg::RAND_W-1:0] : trial;
        num_nxt  = {num_r[wrpp_pkg::RAND_W-2:0], qbit};
        step_nxt = step_r - 1'b1;
        if (step_r == wrpp_pkg::STEP_W'(1)) begin
          lo_nxt    = '0;
          hi_nxt    = IW'(count_r - 1'b1);
          state_nxt = wrpp_pkg::S_SRCH;
        end
      end
      wrpp_pkg::S_SRCH: begin
        // probe mid, or once settled fetch the entry below lo and the rectangle
        if (lo_r < hi_r) begin
          pfx_raddr = mid;
          state_nxt = wrpp_pkg::S_CMP;
        end else begin
          state_nxt = wrpp_pkg::S_FETCH;
        end
      end
      wrpp_pkg::S_CMP: begin
        if (pfx_rdata > rem_r[wrpp_pkg::PREFIX_W-1:0]) begin
          hi_nxt = mid;
        end else begin
          lo_nxt = mid + 1'b1;
        end
        state_nxt = wrpp_pkg::S_SRCH;
      end
      wrpp_pkg::S_FETCH: begin
        x_nxt     = rect_rdata[3*CW-1:2*CW];
        y_nxt     = rect_rdata[2*CW-1:CW];
        num_nxt   = {off_in, (wrpp_pkg::RAND_W - wrpp_pkg::OFF_W)'(0)};
        rem_nxt   = '0;
        dvs_nxt   = wrpp_pkg::PREFIX_W'({1'b0, rect_rdata[CW-1:0]} + 1'b1);
        step_nxt  = wrpp_pkg::STEP_W'(wrpp_pkg::OFF_W);
        state_nxt = wrpp_pkg::S_DIV;
      end
      wrpp_pkg::S_DIV: begin
        rem_nxt  = qbit ? diff[wrpp_pkg::RAND_W-1:0] : trial;
        num_nxt  = {num_r[wrpp_pkg::RAND_W-2:0], qbit};
        step_nxt = step_r - 1'b1;
        if (step_r == wrpp_pkg::STEP_W'(1)) begin
          res_nxt.point_x    = x_r + num_nxt[CW-1:0];
          res_nxt.point_y    = y_r + rem_nxt[CW-1:0];
          res_nxt.rect_index = wrpp_pkg::RIDX_W'(lo_r);
          res_nxt.status     = wrpp_pkg::ST_OK;
          state_nxt          = wrpp_pkg::S_OUT;
        end
      end
      wrpp_pkg::S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = wrpp_pkg::S_IDLE;
        end
      end
      default: state_nxt = wrpp_pkg::S_IDLE;
    endcase
  end

  assign in_stall  = (state_r != wrpp_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
